// ===== design/sunk_pkg.sv =====
`default_nettype none
package sunk_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SRC_W = 20;
  localparam int TGT_W = 20;
  localparam int DIST_W = 32;
  localparam int LIM_W = 7;
  localparam int DATA_W = SRC_W + TGT_W + DIST_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [TGT_W-1:0]  tgt;
    logic [DIST_W-1:0] sq_dist;
    logic [SRC_W-1:0]  src;
  } entry_t;

  typedef struct packed {
    entry_t ent;
    logic   last;
  } item_t;

  // Sort order: target, then distance, then source, all unsigned.
  function automatic logic key_lt(entry_t a, entry_t b);
    return a < b;
  endfunction

endpackage
`default_nettype wire

// ===== design/sunk_front.sv =====
`default_nettype none
module sunk_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [71:0]     in_tdata,
  input  wire logic            in_tlast,
  output logic                 q_valid,
  output sunk_pkg::item_t      q_item,
  input  wire logic            q_pop
);
  import sunk_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;
  item_t             new_item;

  // Unpack the incoming transaction into an item.
  always_comb begin
    new_item.ent.src     = in_tdata[SRC_W-1:0];
    new_item.ent.tgt     = in_tdata[SRC_W+TGT_W-1:SRC_W];
    new_item.ent.sq_dist = in_tdata[DATA_W-1:SRC_W+TGT_W];
    new_item.last        = in_tlast;
  end

  assign in_tready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = mem_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule
`default_nettype wire

// ===== design/sunk_back.sv =====
`default_nettype none
module sunk_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [6:0]        cfg_wr_data,
  input  wire logic              q_valid,
  input  wire sunk_pkg::item_t   q_item,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [71:0]            out_tdata,
  output logic                   out_tlast,
  output logic [0:0]             out_tuser
);
  import sunk_pkg::*;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_DRAIN = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  logic [1:0]       mode_r, mode_nxt;
  logic [LIM_W-1:0] limit_cfg_r;
  logic [LIM_W-1:0] limit;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             ovf_r, ovf_nxt;
  entry_t           cells_r [MAX_ENTRIES];
  entry_t           cells_nxt [MAX_ENTRIES];
  logic             lt [MAX_ENTRIES];
  entry_t           prev_r, prev_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [LIM_W-1:0] grp_r, grp_nxt;
  entry_t           hold_r, hold_nxt;
  logic             hold_v_r, hold_v_nxt;
  entry_t           out_ent_r, out_ent_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;
  logic             out_v_r, out_v_nxt;
  logic             out_free;
  logic             insert;
  entry_t           head;
  logic             dup;
  logic [LIM_W-1:0] gc;
  logic             keep;
  logic             stall;
  logic             step;

  // Configuration register; a zero limit acts as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_cfg_r <= LIM_W'(4);
    end else if (cfg_wr_en) begin
      limit_cfg_r <= cfg_wr_data;
    end
  end
  assign limit = (limit_cfg_r == '0) ? LIM_W'(1) : limit_cfg_r;

  assign q_pop    = (mode_r == MODE_LOAD);
  assign insert   = q_pop && q_valid && (count_r != CNT_W'(MAX_ENTRIES));
  assign out_free = !out_v_r || out_tready;

  // Drain classification of the head cell.
  assign head  = cells_r[0];
  assign dup   = have_prev_r && (head == prev_r);
  assign gc    = (!have_prev_r || head.tgt != prev_r.tgt) ? '0 : grp_r;
  assign keep  = !dup && (gc < limit);
  assign stall = keep && hold_v_r && !out_free;
  assign step  = (mode_r == MODE_DRAIN) && (rem_r != '0) && !stall;

  // Sorted cell row: parallel insertion while loading, shift toward cell 0 while draining.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      lt[i] = (CNT_W'(i) < count_r) && key_lt(q_item.ent, cells_r[i]);
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cells_nxt[i] = cells_r[i];
      if (insert) begin
        if (i > 0 && lt[(i > 0) ? i - 1 : 0]) begin
          cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
        end else if (lt[i] || CNT_W'(i) == count_r) begin
          cells_nxt[i] = q_item.ent;
        end
      end else if (step && i < MAX_ENTRIES - 1) begin
        cells_nxt[i] = cells_r[(i < MAX_ENTRIES - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  // Control sequencing for load, drain and final flush.
  always_comb begin
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    ovf_nxt       = ovf_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    grp_nxt       = grp_r;
    hold_nxt      = hold_r;
    hold_v_nxt    = hold_v_r;
    out_ent_nxt   = out_ent_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_v_nxt     = out_v_r && !out_tready;
    unique case (mode_r)
      MODE_LOAD: begin
        if (q_valid) begin
          if (insert) begin
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (q_item.last) begin
            mode_nxt = MODE_DRAIN;
            rem_nxt  = insert ? count_r + 1'b1 : count_r;
          end
        end
      end
      MODE_DRAIN: begin
        if (rem_r == '0) begin
          mode_nxt = MODE_FLUSH;
        end else if (step) begin
          rem_nxt       = rem_r - 1'b1;
          prev_nxt      = head;
          have_prev_nxt = 1'b1;
          if (!dup) begin
            grp_nxt = gc + 1'b1;
          end
          if (keep) begin
            if (hold_v_r) begin
              out_ent_nxt  = hold_r;
              out_last_nxt = 1'b0;
              out_ovf_nxt  = ovf_r;
              out_v_nxt    = 1'b1;
            end
            hold_nxt   = head;
            hold_v_nxt = 1'b1;
          end
        end
      end
      MODE_FLUSH: begin
        if (out_free) begin
          out_ent_nxt   = hold_r;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = ovf_r;
          out_v_nxt     = 1'b1;
          hold_v_nxt    = 1'b0;
          have_prev_nxt = 1'b0;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          mode_nxt      = MODE_LOAD;
        end
      end
      default: begin
        mode_nxt = MODE_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_LOAD;
      count_r     <= '0;
      rem_r       <= '0;
      ovf_r       <= 1'b0;
      have_prev_r <= 1'b0;
      grp_r       <= '0;
      hold_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      ovf_r       <= ovf_nxt;
      have_prev_r <= have_prev_nxt;
      grp_r       <= grp_nxt;
      hold_v_r    <= hold_v_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    hold_r     <= hold_nxt;
    out_ent_r  <= out_ent_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_ent_r.sq_dist, out_ent_r.tgt, out_ent_r.src};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule
`default_nettype wire

// ===== design/sort_unique_keep_nearest_per_key.sv =====
// Loading takes one entry per cycle through a four-deep input queue while the
// list loads; the queue fills while a list drains. After the last entry, the
// drain examines one stored entry per cycle unless the output stalls.
// Results leave at up to one per cycle; the next list loads after the flush.
// Reset (rst_n low, synchronous) empties the queue and list, limit returns to 4.
`default_nettype none
module sort_unique_keep_nearest_per_key (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,    // source_index, target_index, distance
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,   // out_source, out_target, out_distance
  output logic             out_tlast,
  output logic [0:0]       out_tuser,   // overflowed
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data
);
  import sunk_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  sunk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  sunk_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule
`default_nettype wire

// ===== design/sunk_checker.sv =====
`default_nettype none
module sunk_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Reset empties the input queue.
  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind sort_unique_keep_nearest_per_key sunk_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
